FILE: sv/tpme_pkg.sv
// Package for the stylus-motor emulator: request codes, default geometry
// and stream widths. No dependencies.
package tpme_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_STROBE = 2'd1,
        FUNC_TAKE   = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    localparam int DEF_LINE_DOTS    = 256;
    localparam int DEF_MARGIN_STEPS = 12;
    localparam int DEF_AIR_STEPS    = 140;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int COUNT_W     = 32;
    localparam int BYTE_W      = 8;

endpackage

FILE: sv/thermal_printer_motor_emulator_unit.sv
// Top level of the stylus-motor emulator: request decode, stepping state
// and line store. Depends on tpme_pkg and tpme_ram.
//
// Usage:
//   Requests enter on the s_axis channel, one result per request leaves on
//   the m_axis channel in request order. A request is a timer tick, a write
//   strobe, a line-consumed notice or a read of one line-store byte.
//   Stepping state (step counter, clock level, stylus position, latches and
//   line counters) sits in flip-flops and is updated in the accept cycle.
//   The line store is a synchronous RAM: the byte is read at accept and
//   modified and written back as the request leaves the memory stage, with
//   the last write forwarded to a following request on the same byte.
//   A request passes the memory stage and then the result register before
//   its result is offered on the m_axis channel.
//   Throughput: one request per cycle while the receiver does not stall,
//   limited by the single read and write port of the line store.
//   Reset clears all control state; line-store bytes read as zero until
//   written, tracked by one valid flag per byte, so no clearing pass runs.
//   When the receiver stalls, the result register holds, the memory stage
//   fills, and s_axis_tready drops once both are occupied.
module thermal_printer_motor_emulator_unit #(
    parameter int LINE_DOTS    = tpme_pkg::DEF_LINE_DOTS,
    parameter int MARGIN_STEPS = tpme_pkg::DEF_MARGIN_STEPS,
    parameter int AIR_STEPS    = tpme_pkg::DEF_AIR_STEPS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] func, [2] stop_level, [3] half_rate, [4] stylus, [9:5] read_index
    input  logic [tpme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] paper_latch, [1] encoder_latch, [2] running,
    // [34:3] lines_captured, [42:35] read_data
    output logic [tpme_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int PAPER_STEPS = 2 * MARGIN_STEPS + LINE_DOTS;
    localparam int TOTAL_STEPS = PAPER_STEPS + AIR_STEPS;
    localparam int STORE_BYTES = (LINE_DOTS + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW          = $clog2(TOTAL_STEPS + 1);
    localparam int CW          = tpme_pkg::COUNT_W;
    localparam int BW          = tpme_pkg::BYTE_W;

    localparam logic [PW-1:0] POS_LAST   = PW'(TOTAL_STEPS);
    localparam logic [PW-1:0] LINE_LO    = PW'(MARGIN_STEPS);
    localparam logic [PW-1:0] LINE_HI    = PW'(MARGIN_STEPS + LINE_DOTS);
    localparam logic [PW-1:0] PAPER_HI   = PW'(PAPER_STEPS);
    localparam logic [PW-1:0] DOT_LAST   = PW'(LINE_DOTS - 1);

    function automatic logic on_line(input logic [PW-1:0] p);
        return (p >= LINE_LO) && (p < LINE_HI);
    endfunction

    // input fields
    tpme_pkg::func_t  func;
    logic             stop_level;
    logic             half_rate;
    logic             stylus;
    logic [4:0]       read_index;

    assign func       = tpme_pkg::func_t'(s_axis_tdata[1:0]);
    assign stop_level = s_axis_tdata[2];
    assign half_rate  = s_axis_tdata[3];
    assign stylus     = s_axis_tdata[4];
    assign read_index = s_axis_tdata[9:5];

    // stepping state
    logic [1:0]    hs_reg, hs_next;
    logic          level_reg, level_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] lines_in_reg, lines_in_next;
    logic [CW-1:0] lines_taken_reg, lines_taken_next;
    logic          run_reg, run_next;
    logic          paper_reg, paper_next;
    logic          enc_reg, enc_next;

    // memory stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_read_reg;
    logic          s1_write_reg;
    logic          s1_inrange_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [BW-1:0] s1_mask_reg;
    logic          s1_bit_reg;
    logic          s1_paper_reg, s1_enc_reg, s1_run_reg;
    logic [CW-1:0] s1_lines_reg;
    logic          fwd_hit_reg;
    logic [BW-1:0] fwd_data_reg;
    logic [STORE_BYTES-1:0] valid_reg;

    // result register
    logic                             out_valid_reg, out_valid_next;
    logic [tpme_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic          accept;
    logic          s1_advance;
    logic          wr_fire;
    logic          dot_write;
    logic [PW-1:0] dot;
    logic [AW-1:0] wr_byte;
    logic [BW-1:0] wr_mask;
    logic [AW-1:0] rd_addr;
    logic          rd_inrange;
    logic [AW-1:0] mem_addr;
    logic [BW-1:0] ram_rdata;
    logic [BW-1:0] old_byte;
    logic [BW-1:0] new_byte;
    logic [BW-1:0] rd_byte;

    logic [1:0]    nstep;
    logic          nlevel;
    logic [PW-1:0] np;
    logic          stall;

    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_fire       = s1_valid_reg && s1_write_reg && s1_advance;

    assign dot     = pos_reg - LINE_LO;
    assign wr_byte = AW'(dot >> 3);
    assign wr_mask = BW'(8'h80 >> dot[2:0]);

    assign rd_addr    = AW'(read_index);
    assign rd_inrange = (32'(read_index) < STORE_BYTES);
    assign mem_addr   = (func == tpme_pkg::FUNC_READ) ? rd_addr : wr_byte;

    assign nstep  = hs_reg + 2'd1;
    assign nlevel = half_rate ? nstep[1] : nstep[0];
    assign np     = (pos_reg >= POS_LAST) ? '0 : pos_reg + PW'(1);
    assign stall  = on_line(np) && !on_line(pos_reg) && (lines_taken_reg != lines_in_reg);

    // next stepping state
    always_comb
    begin
        hs_next          = hs_reg;
        level_next       = level_reg;
        pos_next         = pos_reg;
        lines_in_next    = lines_in_reg;
        lines_taken_next = lines_taken_reg;
        run_next         = run_reg;
        paper_next       = paper_reg;
        enc_next         = enc_reg;
        dot_write        = 1'b0;
        if (accept)
        begin
            unique case (func)
                tpme_pkg::FUNC_TICK:
                begin
                    if (run_reg)
                    begin
                        priority if (nlevel && !level_reg)
                        begin
                            // rising edge: step unless motor off or held at line start
                            if (!stop_level && !stall)
                            begin
                                if ((np < PAPER_HI) && !(pos_reg < PAPER_HI))
                                begin
                                    paper_next = 1'b1;
                                end
                                if (on_line(np))
                                begin
                                    enc_next = 1'b1;
                                end
                                pos_next   = np;
                                hs_next    = nstep;
                                level_next = nlevel;
                            end
                        end
                        else if (!nlevel && level_reg)
                        begin
                            // falling edge: capture the dot over the line
                            if (on_line(pos_reg))
                            begin
                                dot_write = 1'b1;
                                if (dot == DOT_LAST)
                                begin
                                    lines_in_next = lines_in_reg + CW'(1);
                                end
                            end
                            hs_next    = nstep;
                            level_next = nlevel;
                        end
                        else
                        begin
                            hs_next = nstep;
                        end
                    end
                end
                tpme_pkg::FUNC_STROBE:
                begin
                    paper_next = 1'b0;
                    enc_next   = 1'b0;
                    if (!stop_level)
                    begin
                        run_next = 1'b1;
                    end
                end
                tpme_pkg::FUNC_TAKE:
                begin
                    if (lines_taken_reg != lines_in_reg)
                    begin
                        lines_taken_next = lines_taken_reg + CW'(1);
                    end
                end
                tpme_pkg::FUNC_READ:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg          <= '0;
            level_reg       <= 1'b0;
            pos_reg         <= POS_LAST;
            lines_in_reg    <= '0;
            lines_taken_reg <= '0;
            run_reg         <= 1'b0;
            paper_reg       <= 1'b0;
            enc_reg         <= 1'b0;
        end
        else
        begin
            hs_reg          <= hs_next;
            level_reg       <= level_next;
            pos_reg         <= pos_next;
            lines_in_reg    <= lines_in_next;
            lines_taken_reg <= lines_taken_next;
            run_reg         <= run_next;
            paper_reg       <= paper_next;
            enc_reg         <= enc_next;
        end
    end

    tpme_ram #(
        .WIDTH (BW),
        .DEPTH (STORE_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (s1_addr_reg),
        .wdata (new_byte),
        .re    (accept),
        .raddr (mem_addr),
        .rdata (ram_rdata)
    );

    // merge forwarded write and never-written bytes
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            old_byte = fwd_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            old_byte = ram_rdata;
        end
        else
        begin
            old_byte = '0;
        end
        new_byte = (old_byte & ~s1_mask_reg) | (s1_bit_reg ? s1_mask_reg : '0);
        rd_byte  = (s1_read_reg && s1_inrange_reg) ? old_byte : '0;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= wr_fire && (s1_addr_reg == mem_addr);
            end
            if (wr_fire)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg    <= (func == tpme_pkg::FUNC_READ);
            s1_write_reg   <= dot_write;
            s1_inrange_reg <= rd_inrange;
            s1_addr_reg    <= mem_addr;
            s1_mask_reg    <= wr_mask;
            s1_bit_reg     <= stylus;
            s1_paper_reg   <= paper_next;
            s1_enc_reg     <= enc_next;
            s1_run_reg     <= run_next;
            s1_lines_reg   <= lines_in_next;
            fwd_data_reg   <= new_byte;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_data_reg <= {5'd0, rd_byte, s1_lines_reg, s1_run_reg, s1_enc_reg, s1_paper_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: sv/tpme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module tpme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
